### design/soil_moisture_average_to_percent_core_macros.svh
// ----------------------------------------------------------------------------
// soil moisture average core assertion macros
// implication and next-cycle assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef SOIL_MOISTURE_AVERAGE_TO_PERCENT_CORE_MACROS_SVH
`define SOIL_MOISTURE_AVERAGE_TO_PERCENT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SMAP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smap assertion failed");
`define SMAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smap assertion failed");
`else
`define SMAP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SMAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/smap_pkg.sv
// ----------------------------------------------------------------------------
// smap_pkg
// shared types and constants of the soil moisture average core
// ----------------------------------------------------------------------------
package smap_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int BLOCK_BITS     = 8;
    localparam int PCT_BITS       = 7;
    localparam int PCT_SCALE      = 100;

    localparam int DRY_RESET_VALUE   = 3200;
    localparam int WET_RESET_VALUE   = 1500;
    localparam int BLOCK_RESET_VALUE = 20;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DRY_LEVEL    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WET_LEVEL    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_PCT_PREP,
        ST_PCT_START,
        ST_PCT_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accumulate;
        logic mean_start;
        logic latch_mean;
        logic prep_pct;
        logic pct_start;
        logic latch_pct;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic block_done;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

### design/soil_moisture_average_to_percent_core.sv
// ----------------------------------------------------------------------------
// soil_moisture_average_to_percent_core
// block average of sensor samples mapped linearly to calibrated percent
//
// channel   direction  handshake              payload
// cfg       in         cfg_write              cfg_index, cfg_data
// in        in         in_valid / in_ready    sample
// out       out        out_valid / out_ready  average_raw, moisture_percent,
//                                             calibration_error
//
// samples that do not close a block are accepted while in_ready stays high in idle
// after a closing sample in_ready stays low until the result is loaded, while the
// shared bit-serial divider runs twice (mean, then percent)
// the output register holds a result while the next block accumulates
// asynchronous active-low reset restores the default levels and clears the sum
// ----------------------------------------------------------------------------
module soil_moisture_average_to_percent_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [smap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]              cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [SAMPLE_BITS-1:0]              sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [SAMPLE_BITS-1:0]              average_raw,
    output logic [smap_pkg::PCT_BITS-1:0]       moisture_percent,
    output logic                                calibration_error
);

    smap_pkg::cmd_t    cmd;
    smap_pkg::status_t status;

    smap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    smap_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .sample            (sample),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .average_raw       (average_raw),
        .moisture_percent  (moisture_percent),
        .calibration_error (calibration_error),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

### design/smap_div.sv
// ----------------------------------------------------------------------------
// smap_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module smap_div #(
    parameter int DIVIDEND_BITS = 20,
    parameter int DIVISOR_BITS  = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0]  den_reg, den_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIVISOR_BITS:0]    rem_shift;
    logic                     fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        fits      = rem_shift >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_BITS'(DIVIDEND_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
            if (fits)
            begin
                rem_next = DIVISOR_BITS'(rem_shift - {1'b0, den_reg});
            end
            else
            begin
                rem_next = rem_shift[DIVISOR_BITS-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/smap_ctrl.sv
// ----------------------------------------------------------------------------
// smap_ctrl
// sequencing state machine: accumulate, mean division, percent division, emit
// ----------------------------------------------------------------------------
module smap_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  smap_pkg::status_t status,
    output smap_pkg::cmd_t    cmd
);

    smap_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smap_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            smap_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accumulate = 1'b1;
                    if (status.block_done)
                    begin
                        state_next = smap_pkg::ST_MEAN_START;
                    end
                end
            end
            smap_pkg::ST_MEAN_START:
            begin
                cmd.mean_start = 1'b1;
                state_next     = smap_pkg::ST_MEAN_WAIT;
            end
            smap_pkg::ST_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.latch_mean = 1'b1;
                    state_next     = smap_pkg::ST_PCT_PREP;
                end
            end
            smap_pkg::ST_PCT_PREP:
            begin
                cmd.prep_pct = 1'b1;
                state_next   = smap_pkg::ST_PCT_START;
            end
            smap_pkg::ST_PCT_START:
            begin
                cmd.pct_start = 1'b1;
                state_next    = smap_pkg::ST_PCT_WAIT;
            end
            smap_pkg::ST_PCT_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.latch_pct = 1'b1;
                    state_next    = smap_pkg::ST_EMIT;
                end
            end
            smap_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = smap_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smap_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/smap_dp.sv
// ----------------------------------------------------------------------------
// smap_dp
// datapath: settings, accumulator, shared divider, clamp and output register
// ----------------------------------------------------------------------------
`include "soil_moisture_average_to_percent_core_macros.svh"

module smap_dp #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [smap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]              cfg_data,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [SAMPLE_BITS-1:0]              average_raw,
    output logic [smap_pkg::PCT_BITS-1:0]       moisture_percent,
    output logic                                calibration_error,
    input  smap_pkg::cmd_t                      cmd,
    output smap_pkg::status_t                   status
);

    localparam int SUM_BITS = SAMPLE_BITS + smap_pkg::BLOCK_BITS;
    localparam int BB       = smap_pkg::BLOCK_BITS;
    localparam logic [SAMPLE_BITS-1:0] DRY_RESET = SAMPLE_BITS'(smap_pkg::DRY_RESET_VALUE);
    localparam logic [SAMPLE_BITS-1:0] WET_RESET = SAMPLE_BITS'(smap_pkg::WET_RESET_VALUE);
    localparam logic [BB-1:0]          BLK_RESET = BB'(smap_pkg::BLOCK_RESET_VALUE);

    logic [SAMPLE_BITS-1:0] dry_level_reg, wet_level_reg;
    logic [BB-1:0]          block_length_reg;
    logic [SUM_BITS-1:0]    sample_sum_reg, sample_sum_next;
    logic [BB-1:0]          sample_index_reg, sample_index_next;
    logic [BB-1:0]          index_inc;
    logic [BB-1:0]          block_n;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [SAMPLE_BITS-1:0] diff_reg;
    logic [SAMPLE_BITS-1:0] clamped;
    logic [smap_pkg::PCT_BITS-1:0] pct_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] average_raw_reg;
    logic [smap_pkg::PCT_BITS-1:0] moisture_percent_reg;
    logic                   calibration_error_reg;
    logic                   cal_bad;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_BITS-1:0]    div_dividend;
    logic [SAMPLE_BITS-1:0] div_divisor;
    logic [SUM_BITS-1:0]    div_quotient;

    // settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_level_reg    <= DRY_RESET;
            wet_level_reg    <= WET_RESET;
            block_length_reg <= BLK_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                smap_pkg::REG_DRY_LEVEL:    dry_level_reg    <= cfg_data;
                smap_pkg::REG_WET_LEVEL:    wet_level_reg    <= cfg_data;
                smap_pkg::REG_BLOCK_LENGTH: block_length_reg <= cfg_data[BB-1:0];
                default:                    ;
            endcase
        end
    end

    // accumulator
    assign block_n   = (block_length_reg == '0) ? BB'(1) : block_length_reg;
    assign index_inc = sample_index_reg + 1'b1;

    always_comb
    begin
        sample_sum_next   = sample_sum_reg;
        sample_index_next = sample_index_reg;
        if (cmd.accumulate)
        begin
            sample_sum_next   = sample_sum_reg + SUM_BITS'(sample);
            sample_index_next = index_inc;
        end
        else if (cmd.latch_mean)
        begin
            sample_sum_next   = '0;
            sample_index_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_sum_reg   <= '0;
            sample_index_reg <= '0;
        end
        else
        begin
            sample_sum_reg   <= sample_sum_next;
            sample_index_reg <= sample_index_next;
        end
    end

    // shared divider
    assign div_start    = cmd.mean_start | cmd.pct_start;
    assign div_dividend = cmd.pct_start
                        ? SUM_BITS'(diff_reg) * SUM_BITS'(smap_pkg::PCT_SCALE)
                        : sample_sum_reg;
    assign div_divisor  = cmd.pct_start ? (dry_level_reg - wet_level_reg)
                                        : SAMPLE_BITS'(block_n);

    smap_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // clamp and percent
    assign cal_bad = dry_level_reg <= wet_level_reg;

    always_comb
    begin
        if (mean_reg < wet_level_reg)
        begin
            clamped = wet_level_reg;
        end
        else if (mean_reg > dry_level_reg)
        begin
            clamped = dry_level_reg;
        end
        else
        begin
            clamped = mean_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_mean)
        begin
            mean_reg <= div_quotient[SAMPLE_BITS-1:0];
        end
        if (cmd.prep_pct)
        begin
            diff_reg <= dry_level_reg - clamped;
        end
        if (cmd.latch_pct)
        begin
            pct_reg <= div_quotient[smap_pkg::PCT_BITS-1:0];
        end
        if (cmd.load_out)
        begin
            average_raw_reg       <= mean_reg;
            moisture_percent_reg  <= cal_bad ? '0 : pct_reg;
            calibration_error_reg <= cal_bad;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.block_done = (index_inc == '0) || (index_inc >= block_n);
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign average_raw       = average_raw_reg;
    assign moisture_percent  = moisture_percent_reg;
    assign calibration_error = calibration_error_reg;

    `SMAP_ASSERT_NEXT(a_block_restart, clk, rst_n, cmd.latch_mean,
        sample_sum_reg == '0 && sample_index_reg == '0)
    `SMAP_ASSERT_IMP(a_load_slot_free, clk, rst_n, cmd.load_out, status.out_free)
    `SMAP_ASSERT_IMP(a_pct_range, clk, rst_n, out_valid_reg,
        moisture_percent_reg <= smap_pkg::PCT_BITS'(smap_pkg::PCT_SCALE))
    `SMAP_ASSERT_IMP(a_error_zero_pct, clk, rst_n, out_valid_reg && calibration_error_reg,
        moisture_percent_reg == '0)

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench for soil_moisture_average_to_percent_core
// streams raw samples in under valid/ready and predicts each closed block's
// floor mean, calibrated percent and calibration error flag in the bench;
// every output transaction is compared with the oldest predicted reading
// under several idling and back-pressure patterns and register settings
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SAMPLE_BITS   = 12;
    localparam int SUM_BITS      = SAMPLE_BITS + 8;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int PAD_BITS      = SAMPLE_BITS - smap_pkg::BLOCK_BITS;
    localparam int SETTLE_CYCLES = 2 * (SAMPLE_BITS + 8) + 24;
    localparam int RANDOM_ROUNDS = 12;
    localparam int LONG_ROUND    = 5;
    localparam int MAX_REPORTS   = 10;

    localparam logic [smap_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]          average_raw;
        logic [smap_pkg::PCT_BITS-1:0]   moisture_percent;
        logic                            calibration_error;
    } reading_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write = 1'b0;
    logic [smap_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [SAMPLE_BITS-1:0]              cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [SAMPLE_BITS-1:0]              sample = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [SAMPLE_BITS-1:0]              average_raw;
    logic [smap_pkg::PCT_BITS-1:0]       moisture_percent;
    logic                                calibration_error;

    // bench copy of the block's registers and accumulator
    logic [SAMPLE_BITS-1:0]              dry_level_q;
    logic [SAMPLE_BITS-1:0]              wet_level_q;
    logic [smap_pkg::BLOCK_BITS-1:0]     block_length_q;
    logic [smap_pkg::BLOCK_BITS-1:0]     block_count_q;
    logic [SUM_BITS-1:0]                 block_sum_q;
    reading_t                            pending_readings[$];

    int unsigned               mismatch_count = 0;
    bit                        sender_idles = 1'b0;
    bit                        receiver_stalls = 1'b0;
    int unsigned               idle_percent = 77;
    int unsigned               holdoff_request = 0;
    int unsigned               holdoff_left = 0;

    soil_moisture_average_to_percent_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample            (sample),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .average_raw       (average_raw),
        .moisture_percent  (moisture_percent),
        .calibration_error (calibration_error)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void apply_register(input logic [smap_pkg::CFG_INDEX_BITS-1:0] idx,
                                           input logic [SAMPLE_BITS-1:0] data);
        case (idx)
            smap_pkg::REG_DRY_LEVEL:    dry_level_q = data;
            smap_pkg::REG_WET_LEVEL:    wet_level_q = data;
            smap_pkg::REG_BLOCK_LENGTH: block_length_q = data[smap_pkg::BLOCK_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic void accumulate_sample(input logic [SAMPLE_BITS-1:0] value);
        int unsigned n;
        int unsigned mean;
        int unsigned level;
        int unsigned pct;
        reading_t    r;
        n = (block_length_q == 0) ? 1 : block_length_q;
        block_sum_q = block_sum_q + value;
        block_count_q = block_count_q + 1'b1;
        if (block_count_q != 0 && block_count_q < n)
            return;
        mean = block_sum_q / n;
        r.average_raw = mean[SAMPLE_BITS-1:0];
        if (dry_level_q <= wet_level_q)
        begin
            r.moisture_percent = '0;
            r.calibration_error = 1'b1;
        end
        else
        begin
            level = r.average_raw;
            if (level < wet_level_q)
                level = wet_level_q;
            if (level > dry_level_q)
                level = dry_level_q;
            pct = ((dry_level_q - level) * smap_pkg::PCT_SCALE)
                  / (dry_level_q - wet_level_q);
            r.moisture_percent = pct[smap_pkg::PCT_BITS-1:0];
            r.calibration_error = 1'b0;
        end
        block_sum_q = '0;
        block_count_q = '0;
        pending_readings.push_back(r);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int unsigned pick;
        int          near;
        pick = $urandom_range(0, 7);
        case (pick)
            0: return '0;
            1: return SAMPLE_MAX[SAMPLE_BITS-1:0];
            2, 3:
                near = int'(pick == 2 ? dry_level_q : wet_level_q)
                       + int'($urandom_range(0, 64)) - 32;
            default: return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        endcase
        if (near < 0)
            near = 0;
        if (near > SAMPLE_MAX)
            near = SAMPLE_MAX;
        return near[SAMPLE_BITS-1:0];
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        sender_idles = (mode == IDLE_SEND || mode == IDLE_BOTH);
        receiver_stalls = (mode == IDLE_RECV || mode == IDLE_BOTH);
        idle_percent = (mode == IDLE_BOTH) ? 23 : 77;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        int unsigned gap;
        gap = 0;
        while (sender_idles && $urandom_range(0, 99) < idle_percent)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_sample(value);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [smap_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [SAMPLE_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        apply_register(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [SAMPLE_BITS-1:0] dry,
                             input logic [SAMPLE_BITS-1:0] wet,
                             input logic [SAMPLE_BITS-1:0] block_data);
        wait_for_results();
        write_register(smap_pkg::REG_DRY_LEVEL, dry);
        write_register(smap_pkg::REG_WET_LEVEL, wet);
        write_register(smap_pkg::REG_BLOCK_LENGTH, block_data);
    endtask

    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        for (int i = 0; i < smap_pkg::BLOCK_RESET_VALUE; i++)
            send_sample(i[0] ? SAMPLE_MAX[SAMPLE_BITS-1:0] : '0);
    endtask

    task automatic test_calibration_clamps();
        set_idling(IDLE_NONE);
        configure(12'd3000, 12'd1000, 12'd1);
        send_sample(SAMPLE_MAX[SAMPLE_BITS-1:0]);
        send_sample('0);
        send_sample(12'd3000);
        send_sample(12'd1000);
        send_sample(12'd2000);
    endtask

    task automatic test_calibration_error();
        set_idling(IDLE_NONE);
        // inverted levels, then equal levels with a zero block length
        configure(12'd1000, 12'd3000, 12'd1);
        send_sample(12'd2000);
        configure(12'd2000, 12'd2000, 12'd0);
        send_sample(12'd2000);
    endtask

    task automatic test_block_shortened();
        set_idling(IDLE_NONE);
        configure(SAMPLE_MAX[SAMPLE_BITS-1:0], '0, 12'd4);
        send_sample(SAMPLE_MAX[SAMPLE_BITS-1:0]);
        send_sample(SAMPLE_MAX[SAMPLE_BITS-1:0]);
        wait_for_results();
        write_register(REG_UNUSED, 12'hfff);
        // upper data bits are dropped, leaving a block length of one
        write_register(smap_pkg::REG_BLOCK_LENGTH, 12'hf01);
        send_sample(SAMPLE_MAX[SAMPLE_BITS-1:0]);
    endtask

    task automatic test_backpressure();
        set_idling(IDLE_NONE);
        configure(12'd3200, 12'd1500, 12'd1);
        holdoff_request = 400;
        for (int i = 0; i < 40; i++)
            send_sample(random_sample());
        wait_for_results();
    endtask

    task automatic randomise_settings(input int round_no);
        int unsigned dry;
        int unsigned wet;
        int unsigned swap;
        int unsigned len;
        dry = $urandom_range(0, SAMPLE_MAX);
        wet = $urandom_range(0, SAMPLE_MAX);
        case ($urandom_range(0, 9))
            0:
            begin
                dry = SAMPLE_MAX;
                wet = 0;
            end
            1: wet = dry;
            2:
            begin
                wet = $urandom_range(0, SAMPLE_MAX - 1);
                dry = wet + 1;
            end
            3:
            begin
                if (dry > wet)
                begin
                    swap = dry;
                    dry = wet;
                    wet = swap;
                end
            end
            default:
            begin
                if (dry < wet)
                begin
                    swap = dry;
                    dry = wet;
                    wet = swap;
                end
            end
        endcase
        if (round_no == LONG_ROUND)
            len = 255;
        else
        begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1, 2, 3, 4, 5, 6, 7: len = $urandom_range(1, 8);
                default: len = $urandom_range(9, 40);
            endcase
        end
        wait_for_results();
        if ($urandom_range(0, 1))
            write_register(REG_UNUSED, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
        write_register(smap_pkg::REG_DRY_LEVEL, dry[SAMPLE_BITS-1:0]);
        write_register(smap_pkg::REG_WET_LEVEL, wet[SAMPLE_BITS-1:0]);
        write_register(smap_pkg::REG_BLOCK_LENGTH,
                       {PAD_BITS'($urandom_range(0, 15)), len[smap_pkg::BLOCK_BITS-1:0]});
    endtask

    task automatic test_random_traffic();
        int unsigned count;
        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            randomise_settings(r);
            set_idling(idle_mode_t'(r % 4));
            count = (r == LONG_ROUND) ? 300 : 110;
            for (int i = 0; i < count; i++)
                send_sample(random_sample());
        end
    endtask

    // receiver side: long hold-off on request, otherwise random stalls
    always @(posedge clk)
    begin
        if (holdoff_request != 0)
        begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left != 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !(receiver_stalls && $urandom_range(0, 99) < idle_percent);
    end

    always @(posedge clk)
    begin : check_reading
        reading_t want;
        reading_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {average_raw, moisture_percent, calibration_error};
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected transaction: average_raw %0d percent %0d error %0d",
                             got.average_raw, got.moisture_percent, got.calibration_error);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display(
                            "mismatch: want avg %0d pct %0d err %0d, got avg %0d pct %0d err %0d",
                            want.average_raw, want.moisture_percent,
                            want.calibration_error, got.average_raw,
                            got.moisture_percent, got.calibration_error);
                end
            end
        end
    end

    initial
    begin
        dry_level_q = SAMPLE_BITS'(smap_pkg::DRY_RESET_VALUE);
        wet_level_q = SAMPLE_BITS'(smap_pkg::WET_RESET_VALUE);
        block_length_q = smap_pkg::BLOCK_BITS'(smap_pkg::BLOCK_RESET_VALUE);
        block_count_q = '0;
        block_sum_q = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_calibration_clamps();
        test_calibration_error();
        test_block_shortened();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
